### rtl/core/bounded_ordered_list_engine_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ordered list engine
// Concurrent checks, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTH
`define BOLE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bole assertion failed");
`define BOLE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bole assertion failed");
`else
`define BOLE_ASSERT(name, clk, rst_n, prop)
`define BOLE_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

### rtl/core/bole_pkg.sv
// ---------------------------------------------------------------------------
// bole_pkg
// Shared codes, defaults and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bole_pkg;

  localparam int unsigned MAX_NODES_DEF = 64;
  localparam int unsigned DATA_BITS_DEF = 32;

  localparam logic [1:0] OP_APPEND       = 2'd0;
  localparam logic [1:0] OP_INSERT_FRONT = 2'd1;
  localparam logic [1:0] OP_REMOVE       = 2'd2;
  localparam logic [1:0] OP_SEARCH       = 2'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INS_RD,        // read link of free head, write data there
    CMD_INS_FIRST,     // node links to itself, becomes tail
    CMD_INS_RD_TAIL,   // pop free list, read link of tail
    CMD_INS_LINK_NEW,  // new node takes tail's old successor
    CMD_INS_LINK_TAIL, // tail links to new node
    CMD_WALK_RD_TAIL,  // start walk at tail
    CMD_WALK_FIRST,    // step to head, load node count
    CMD_WALK_HOP,      // step to next node
    CMD_REM_UNLINK,    // predecessor skips current node
    CMD_REM_FREE       // current node onto free list
  } cmd_e;

  typedef struct packed {
    cmd_e    op;
    logic    load;
    logic    fin;
    status_e status;
    logic    found;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic is_insert;
    logic is_remove;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

### rtl/core/bounded_ordered_list_engine_core.sv
// ---------------------------------------------------------------------------
// bounded_ordered_list_engine_core
// Bounded circular singly linked list with free list, one op per command.
// ---------------------------------------------------------------------------
// Usage: drive op_i and value_i with start_i high; the command beat is taken
// at the rising edge where start_i is high and busy_o is low. Exactly one
// result beat follows, shown for a single cycle with done_o high. There is no
// back-pressure on results: the receiver must take the beat in that cycle.
// An insert into a full list, or a remove/search on an empty list, returns
// its status without touching the node memories. Search and remove compare
// nodes head first, up to the count; a remove that hits then unlinks the
// node and puts it onto the free list.
// The walk is bound by the node memories: one link read per cycle.
// busy_o is already low in the result cycle, so the next command may be
// taken there. No clearing pass after reset: never-written link entries
// are recognized by a high-water mark and read as the initial free chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_ordered_list_engine_core
  import bole_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF, // 2 .. 4096 nodes; entry_count_o holds only 7 bits
  parameter int unsigned DATA_BITS = DATA_BITS_DEF  // stored/compared bits, 8 .. 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command beat
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] value_i,
  // result beat
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic               found_o,
  output logic signed [31:0] removed_value_o,
  output logic [6:0]         entry_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy;

  // Sequencer; start is qualified by busy here so the FSM sees only accepts.
  bole_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i && !busy),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Node memories, list pointers and result registers.
  bole_dpath #(
    .MAX_NODES (MAX_NODES),
    .DATA_BITS (DATA_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (op_i),
    .value_i         (value_i),
    .stat_o          (stat),
    .status_o        (status_o),
    .found_o         (found_o),
    .removed_value_o (removed_value_o),
    .entry_count_o   (entry_count_o)
  );

  assign busy_o = busy;

endmodule

### rtl/core/bole_ram.sv
// ---------------------------------------------------------------------------
// bole_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bole_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bole_ctrl.sv
// ---------------------------------------------------------------------------
// bole_ctrl
// Sequencer: steps each operation through the datapath commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_ordered_list_engine_core_assert.svh"

module bole_ctrl
  import bole_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_B,
    S_INS_C,
    S_INS_D,
    S_WALK_FIRST,
    S_CMP,
    S_REM
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = CMD_NONE;
    cmd_o.status = ST_OK;
    state_d      = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_insert) begin
          if (stat_i.full) begin
            cmd_o.fin    = 1'b1;
            cmd_o.status = ST_FULL;
            state_d      = S_IDLE;
          end else begin
            cmd_o.op = CMD_INS_RD;
            state_d  = S_INS_B;
          end
        end else if (stat_i.empty) begin
          cmd_o.fin    = 1'b1;
          cmd_o.status = ST_EMPTY;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = CMD_WALK_RD_TAIL;
          state_d  = S_WALK_FIRST;
        end
      end
      S_INS_B: begin
        if (stat_i.empty) begin
          cmd_o.op  = CMD_INS_FIRST;
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.op = CMD_INS_RD_TAIL;
          state_d  = S_INS_C;
        end
      end
      S_INS_C: begin
        cmd_o.op = CMD_INS_LINK_NEW;
        state_d  = S_INS_D;
      end
      S_INS_D: begin
        cmd_o.op  = CMD_INS_LINK_TAIL;
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      S_WALK_FIRST: begin
        cmd_o.op = CMD_WALK_FIRST;
        state_d  = S_CMP;
      end
      S_CMP: begin
        if (stat_i.hit) begin
          if (stat_i.is_remove) begin
            cmd_o.op = CMD_REM_UNLINK;
            state_d  = S_REM;
          end else begin
            cmd_o.fin   = 1'b1;
            cmd_o.found = 1'b1;
            state_d     = S_IDLE;
          end
        end else if (stat_i.last) begin
          cmd_o.fin    = 1'b1;
          cmd_o.status = ST_NOT_FOUND;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = CMD_WALK_HOP;
        end
      end
      S_REM: begin
        cmd_o.op    = CMD_REM_FREE;
        cmd_o.fin   = 1'b1;
        cmd_o.found = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
      done_q  <= cmd_o.fin;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  `BOLE_ASSERT_ALWAYS(a_done_not_busy, clk_i, done_q |-> !busy_q)
  `BOLE_ASSERT(a_accept_busy, clk_i, rst_ni, (start_i && !busy_q) |=> busy_q)
  `BOLE_ASSERT(a_fin_done, clk_i, rst_ni, cmd_o.fin |=> (done_q && !busy_q))

endmodule

### rtl/core/bole_dpath.sv
// ---------------------------------------------------------------------------
// bole_dpath
// Node memories, list pointers, walk registers and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_ordered_list_engine_core_assert.svh"

module bole_dpath
  import bole_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF,
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] value_i,
  output dp_stat_t           stat_o,
  output logic [1:0]         status_o,
  output logic               found_o,
  output logic signed [31:0] removed_value_o,
  output logic [6:0]         entry_count_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

  logic [DATA_BITS-1:0] key_q;
  logic [1:0]           op_q;
  logic [AW-1:0]        free_head_q, tail_q, node_q, cur_q, prev_q, rd_addr_q;
  logic [CW-1:0]        total_q, wm_q, left_q;
  logic                 rd_fresh_q;
  logic [31:0]          removed_q;
  status_e              status_q;
  logic                 found_q;

  logic                 link_we, data_we;
  logic [AW-1:0]        link_waddr, link_wdata, link_raddr, link_rdata, link_val;
  logic [DATA_BITS-1:0] data_rdata;
  logic [63:0]          value_wide, data_wide;
  logic [CW+6:0]        count_wide;

  assign value_wide = {32'b0, unsigned'(value_i)};
  assign data_wide  = 64'(data_rdata);
  assign count_wide = {7'b0, total_q};

  // Nodes at or above the watermark were never written: their link is i+1, 0 for the last.
  assign link_val = rd_fresh_q ? ((rd_addr_q == LAST_IDX) ? '0 : rd_addr_q + 1'b1)
                               : link_rdata;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    link_raddr = '0;
    data_we    = 1'b0;
    case (cmd_i.op)
      CMD_INS_RD: begin
        link_raddr = free_head_q;
        data_we    = 1'b1;
      end
      CMD_INS_FIRST: begin
        link_we    = 1'b1;
        link_waddr = node_q;
        link_wdata = node_q;
      end
      CMD_INS_RD_TAIL: begin
        link_raddr = tail_q;
      end
      CMD_INS_LINK_NEW: begin
        link_we    = 1'b1;
        link_waddr = node_q;
        link_wdata = link_val;
      end
      CMD_INS_LINK_TAIL: begin
        link_we    = 1'b1;
        link_waddr = tail_q;
        link_wdata = node_q;
      end
      CMD_WALK_RD_TAIL: begin
        link_raddr = tail_q;
      end
      CMD_WALK_FIRST, CMD_WALK_HOP: begin
        link_raddr = link_val;
      end
      CMD_REM_UNLINK: begin
        link_we    = 1'b1;
        link_waddr = prev_q;
        link_wdata = link_val;
      end
      CMD_REM_FREE: begin
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = free_head_q;
      end
      default: begin
      end
    endcase
  end

  bole_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_NODES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  bole_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (MAX_NODES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (free_head_q),
    .wdata_i (key_q),
    .raddr_i (link_raddr),
    .rdata_o (data_rdata)
  );

  // List state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      tail_q      <= '0;
      total_q     <= '0;
      wm_q        <= '0;
    end else begin
      if (link_we && (CW'(link_waddr) == wm_q)) begin
        wm_q <= wm_q + 1'b1;
      end
      case (cmd_i.op)
        CMD_INS_FIRST: begin
          free_head_q <= link_val;
          tail_q      <= node_q;
          total_q     <= total_q + 1'b1;
        end
        CMD_INS_RD_TAIL: begin
          free_head_q <= link_val;
        end
        CMD_INS_LINK_TAIL: begin
          if (op_q == OP_APPEND) begin
            tail_q <= node_q;
          end
          total_q <= total_q + 1'b1;
        end
        CMD_REM_FREE: begin
          free_head_q <= cur_q;
          total_q     <= total_q - 1'b1;
          if (total_q == CW'(1)) begin
            tail_q <= '0;
          end else if (cur_q == tail_q) begin
            tail_q <= prev_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Walk and result registers
  always_ff @(posedge clk_i) begin
    rd_addr_q  <= link_raddr;
    rd_fresh_q <= (CW'(link_raddr) >= wm_q);
    if (cmd_i.load) begin
      op_q      <= op_i;
      key_q     <= value_wide[DATA_BITS-1:0];
      removed_q <= '0;
    end
    case (cmd_i.op)
      CMD_INS_RD: begin
        node_q <= free_head_q;
      end
      CMD_WALK_RD_TAIL: begin
        cur_q <= tail_q;
      end
      CMD_WALK_FIRST: begin
        prev_q <= cur_q;
        cur_q  <= link_val;
        left_q <= total_q;
      end
      CMD_WALK_HOP: begin
        prev_q <= cur_q;
        cur_q  <= link_val;
        left_q <= left_q - 1'b1;
      end
      CMD_REM_UNLINK: begin
        removed_q <= data_wide[31:0];
      end
      default: begin
      end
    endcase
    if (cmd_i.fin) begin
      status_q <= cmd_i.status;
      found_q  <= cmd_i.found;
    end
  end

  always_comb begin
    stat_o.full      = (total_q == CW'(MAX_NODES));
    stat_o.empty     = (total_q == '0);
    stat_o.is_insert = op_q inside {OP_APPEND, OP_INSERT_FRONT};
    stat_o.is_remove = (op_q == OP_REMOVE);
    stat_o.hit       = (data_rdata == key_q);
    stat_o.last      = (left_q == CW'(1));
  end

  assign status_o        = status_q;
  assign found_o         = found_q;
  assign removed_value_o = signed'(removed_q);
  assign entry_count_o   = count_wide[6:0];

  `BOLE_ASSERT(a_total_bound, clk_i, rst_ni, total_q <= CW'(MAX_NODES))
  `BOLE_ASSERT(a_wm_covers_live, clk_i, rst_ni, wm_q >= total_q)
  `BOLE_ASSERT(a_free_drops_count, clk_i, rst_ni,
               (cmd_i.op == CMD_REM_FREE) |=> (total_q == $past(total_q) - CW'(1)))

endmodule
